@@ rtl/core/xlce_pkg.sv @@
// Package: sizes, codes, state and control types for the XOR-linked list editor.
`timescale 1ns / 1ps
`default_nettype none
package xlce_pkg;

  localparam int INDEX_BITS  = 20;
  localparam int NODE_COUNT  = 1048575;
  localparam int WORD_BITS   = 64;
  localparam int VAL_BITS    = WORD_BITS - INDEX_BITS;
  localparam int ADDR_BITS   = $clog2(NODE_COUNT);
  localparam int ACTION_BITS = 3;
  localparam int READ_BITS   = 44;

  localparam logic [INDEX_BITS-1:0] CUR_RST       = '0;
  localparam logic [INDEX_BITS-1:0] CUR_LEFT_RST  = '0;
  localparam logic [INDEX_BITS-1:0] CUR_RIGHT_RST = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] FREE_TOP_RST   = INDEX_BITS'(NODE_COUNT - 1);
  localparam logic [INDEX_BITS-1:0] FREE_BELOW_RST = INDEX_BITS'(NODE_COUNT - 2);
  localparam logic [INDEX_BITS-1:0] FREE_ABOVE_RST = INDEX_BITS'(NODE_COUNT);
  localparam logic [INDEX_BITS-1:0] CLR_LAST       = INDEX_BITS'(NODE_COUNT - 1);
  localparam logic [INDEX_BITS:0]   NODE_LIMIT     = (INDEX_BITS + 1)'(NODE_COUNT);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LEFT      = 3'd0,
    ACT_RIGHT     = 3'd1,
    ACT_OVERWRITE = 3'd2,
    ACT_INSERT    = 3'd3,
    ACT_DELETE    = 3'd4,
    ACT_READ      = 3'd5
  } xlce_action_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L_RD,
    ST_L_UPD,
    ST_R_RD,
    ST_R_UPD,
    ST_OW_WR,
    ST_RD_RD,
    ST_RD_OUT,
    ST_INS_FRD,
    ST_INS_FUPD,
    ST_INS_C_RD,
    ST_INS_C_WR,
    ST_INS_F_WR,
    ST_INS_R_RD,
    ST_INS_R_WR,
    ST_DEL_L_RD,
    ST_DEL_L_WR,
    ST_DEL_R_RD,
    ST_DEL_R_WR,
    ST_DEL_L2_RD,
    ST_DEL_L2_UPD,
    ST_DEL_FT_WR,
    ST_DEL_G_WR
  } xlce_state_e;

  typedef struct packed {
    xlce_state_e             state;
    logic                    re;
    logic                    we;
    logic                    stall;
    logic [INDEX_BITS-1:0]   clr_idx;
  } xlce_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/xor_linked_list_cursor_editor.sv @@
// Top level: XOR-linked list editor with cursor and free-node stack over a node RAM.
// Each action runs as a sequence of node RAM read and write steps once it is accepted;
// unused action codes are taken and dropped. The single node RAM port pair
// (one read or one write per cycle, registered read) sets the length of each sequence.
// A read takes a RAM read step, then an output step that fills the output register.
// After reset, in_stall_o stays high while a clearing pass writes all 1048575 nodes.
`timescale 1ns / 1ps
`default_nettype none
module xor_linked_list_cursor_editor (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic        [xlce_pkg::ACTION_BITS-1:0] action_i,
  input  wire logic signed [xlce_pkg::READ_BITS-1:0]   value_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed      [xlce_pkg::READ_BITS-1:0]   read_value_o
);
  import xlce_pkg::*;

  xlce_ctl_t ctl;

  logic [INDEX_BITS-1:0] cur_q, cur_d, cl_q, cl_d, cr_q, cr_d;
  logic [INDEX_BITS-1:0] ft_q, ft_d, fb_q, fb_d, fa_q, fa_d;
  logic [INDEX_BITS-1:0] tmp_q, tmp_d;
  logic [VAL_BITS-1:0]   val_q;
  logic                  out_valid_q;
  logic signed [READ_BITS-1:0] read_value_q;
  logic                  rd_oob_q;

  logic [INDEX_BITS-1:0] rd_idx, wr_idx;
  logic [VAL_BITS-1:0]   wr_val;
  logic [INDEX_BITS-1:0] xa, xb, xc, xor_res;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic [INDEX_BITS-1:0] r_link;
  logic [VAL_BITS-1:0]   r_val;
  logic                  rd_in_range, wr_in_range, mem_we, mem_re, accept, out_load;

  assign in_stall_o = ctl.stall;
  assign accept     = in_valid_i && !ctl.stall;
  assign out_load   = (ctl.state == ST_RD_OUT) && !(out_valid_q && out_stall_i);

  xlce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .out_busy_i (out_valid_q && out_stall_i),
    .ctl_o      (ctl)
  );

  assign r_link = rd_oob_q ? '0 : ram_rdata[INDEX_BITS-1:0];
  assign r_val  = rd_oob_q ? '0 : ram_rdata[WORD_BITS-1:INDEX_BITS];

  // address, value and link operand selection per step
  always_comb begin
    rd_idx = cur_q;
    wr_idx = cur_q;
    wr_val = r_val;
    xa     = '0;
    xb     = '0;
    xc     = '0;
    unique case (ctl.state)
      ST_CLEAR: begin
        wr_idx = ctl.clr_idx;
        wr_val = '1;
        xa     = (ctl.clr_idx == '0) ? '0 : ctl.clr_idx - 1'b1;
        xb     = ctl.clr_idx + 1'b1;
      end
      ST_L_RD:       rd_idx = cl_q;
      ST_R_RD:       rd_idx = cr_q;
      ST_INS_FRD:    rd_idx = fb_q;
      ST_INS_R_RD:   rd_idx = cr_q;
      ST_DEL_L_RD:   rd_idx = cl_q;
      ST_DEL_R_RD:   rd_idx = cr_q;
      ST_DEL_L2_RD:  rd_idx = cl_q;
      ST_L_UPD: begin
        xa = r_link; xb = cur_q;
      end
      ST_R_UPD: begin
        xa = r_link; xb = cur_q;
      end
      ST_INS_FUPD: begin
        xa = r_link; xb = fa_q;
      end
      ST_DEL_L2_UPD: begin
        xa = r_link; xb = cr_q;
      end
      ST_OW_WR: begin
        wr_val = val_q; xa = cl_q; xb = cr_q;
      end
      ST_INS_C_WR: begin
        xa = cl_q; xb = fa_q;
      end
      ST_INS_F_WR: begin
        wr_idx = fa_q; wr_val = val_q; xa = cur_q; xb = cr_q;
      end
      ST_INS_R_WR: begin
        wr_idx = cr_q; xa = fa_q; xb = r_link; xc = cur_q;
      end
      ST_DEL_L_WR: begin
        wr_idx = cl_q; xa = r_link; xb = cur_q; xc = cr_q;
      end
      ST_DEL_R_WR: begin
        wr_idx = cr_q; xa = cl_q; xb = r_link; xc = cur_q;
      end
      ST_DEL_FT_WR: begin
        wr_idx = ft_q; wr_val = '1; xa = fb_q; xb = cur_q;
      end
      ST_DEL_G_WR: begin
        wr_val = '1; xa = ft_q; xb = cur_q;
      end
      default: begin
        rd_idx = cur_q;
      end
    endcase
  end

  // shared link unit
  assign xor_res = xa ^ xb ^ xc;

  assign rd_in_range = {1'b0, rd_idx} < NODE_LIMIT;
  assign wr_in_range = {1'b0, wr_idx} < NODE_LIMIT;
  assign mem_we      = ctl.we && wr_in_range;
  assign mem_re      = ctl.re && rd_in_range;

  xlce_ram #(
    .Width (WORD_BITS),
    .Depth (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx[ADDR_BITS-1:0]),
    .wdata_i ({wr_val, xor_res}),
    .re_i    (mem_re),
    .raddr_i (rd_idx[ADDR_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cur_d = cur_q;
    cl_d  = cl_q;
    cr_d  = cr_q;
    ft_d  = ft_q;
    fb_d  = fb_q;
    fa_d  = fa_q;
    tmp_d = tmp_q;
    unique case (ctl.state)
      ST_L_UPD: begin
        cr_d = cur_q; cur_d = cl_q; cl_d = xor_res;
      end
      ST_R_UPD: begin
        cl_d = cur_q; cur_d = cr_q; cr_d = xor_res;
      end
      ST_INS_FRD:    fa_d = ft_q;
      ST_INS_FUPD: begin
        ft_d = fb_q; fb_d = xor_res;
      end
      ST_INS_R_WR: begin
        cl_d = cur_q; cur_d = fa_q;
      end
      ST_DEL_L2_UPD: tmp_d = xor_res;
      ST_DEL_G_WR: begin
        cur_d = cl_q; cl_d = tmp_q; fb_d = ft_q; ft_d = cur_q; fa_d = cur_q;
      end
      default: begin
        tmp_d = tmp_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= CUR_RST;
      cl_q        <= CUR_LEFT_RST;
      cr_q        <= CUR_RIGHT_RST;
      ft_q        <= FREE_TOP_RST;
      fb_q        <= FREE_BELOW_RST;
      fa_q        <= FREE_ABOVE_RST;
      out_valid_q <= 1'b0;
    end else begin
      cur_q <= cur_d;
      cl_q  <= cl_d;
      cr_q  <= cr_d;
      ft_q  <= ft_d;
      fb_q  <= fb_d;
      fa_q  <= fa_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    if (accept) begin
      val_q <= VAL_BITS'(value_i);
    end
    if (ctl.re) begin
      rd_oob_q <= !rd_in_range;
    end
    if (out_load) begin
      read_value_q <= READ_BITS'(signed'(r_val));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.re && ctl.we))
    else $error("node RAM read and write in the same cycle");

  a_read_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ACT_READ) |=> ctl.state == ST_RD_RD)
    else $error("read item did not start a RAM read");

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctl.state) == ST_RD_OUT)
    else $error("result raised outside the read step");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.state == ST_CLEAR |-> in_stall_o && !out_valid_q)
    else $error("item or result during clearing pass");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> {1'b0, wr_idx} < NODE_LIMIT)
    else $error("node RAM write outside the store");

endmodule
`default_nettype wire

@@ rtl/core/xlce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module xlce_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/xlce_ctrl.sv @@
// Sequencer: clearing sweep counter and per-action memory step state machine.
`timescale 1ns / 1ps
`default_nettype none
module xlce_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic [xlce_pkg::ACTION_BITS-1:0] action_i,
  input  wire logic                            out_busy_i,
  output xlce_pkg::xlce_ctl_t                  ctl_o
);
  import xlce_pkg::*;

  xlce_state_e           state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (xlce_action_e'(action_i))
            ACT_LEFT:      state_d = ST_L_RD;
            ACT_RIGHT:     state_d = ST_R_RD;
            ACT_OVERWRITE: state_d = ST_OW_WR;
            ACT_INSERT:    state_d = ST_INS_FRD;
            ACT_DELETE:    state_d = ST_DEL_L_RD;
            ACT_READ:      state_d = ST_RD_RD;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_L_RD:       state_d = ST_L_UPD;
      ST_L_UPD:      state_d = ST_IDLE;
      ST_R_RD:       state_d = ST_R_UPD;
      ST_R_UPD:      state_d = ST_IDLE;
      ST_OW_WR:      state_d = ST_IDLE;
      ST_RD_RD:      state_d = ST_RD_OUT;
      ST_RD_OUT: begin
        if (!out_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_INS_FRD:    state_d = ST_INS_FUPD;
      ST_INS_FUPD:   state_d = ST_INS_C_RD;
      ST_INS_C_RD:   state_d = ST_INS_C_WR;
      ST_INS_C_WR:   state_d = ST_INS_F_WR;
      ST_INS_F_WR:   state_d = ST_INS_R_RD;
      ST_INS_R_RD:   state_d = ST_INS_R_WR;
      ST_INS_R_WR:   state_d = ST_IDLE;
      ST_DEL_L_RD:   state_d = ST_DEL_L_WR;
      ST_DEL_L_WR:   state_d = ST_DEL_R_RD;
      ST_DEL_R_RD:   state_d = ST_DEL_R_WR;
      ST_DEL_R_WR:   state_d = ST_DEL_L2_RD;
      ST_DEL_L2_RD:  state_d = ST_DEL_L2_UPD;
      ST_DEL_L2_UPD: state_d = ST_DEL_FT_WR;
      ST_DEL_FT_WR:  state_d = ST_DEL_G_WR;
      ST_DEL_G_WR:   state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.state   = state_q;
    ctl_o.clr_idx = clr_q;
    ctl_o.stall   = (state_q != ST_IDLE);
    ctl_o.re      = 1'b0;
    ctl_o.we      = 1'b0;
    unique case (state_q)
      ST_L_RD, ST_R_RD, ST_RD_RD, ST_INS_FRD, ST_INS_C_RD, ST_INS_R_RD,
      ST_DEL_L_RD, ST_DEL_R_RD, ST_DEL_L2_RD: begin
        ctl_o.re = 1'b1;
      end
      ST_CLEAR, ST_OW_WR, ST_INS_C_WR, ST_INS_F_WR, ST_INS_R_WR,
      ST_DEL_L_WR, ST_DEL_R_WR, ST_DEL_FT_WR, ST_DEL_G_WR: begin
        ctl_o.we = 1'b1;
      end
      default: begin
        ctl_o.re = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sim/xor_linked_list_cursor_editor_tb.sv @@
// Testbench for the XOR-linked list editor: directed table, random edits, predictor check.
`timescale 1ns / 1ps
module xor_linked_list_cursor_editor_tb;
  import xlce_pkg::*;

  localparam logic [ACTION_BITS-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_7 = 3'd7;
  localparam logic [READ_BITS-1:0]   VAL_MAX     = {1'b0, {(READ_BITS-1){1'b1}}};
  localparam logic [READ_BITS-1:0]   VAL_MIN     = {1'b1, {(READ_BITS-1){1'b0}}};
  localparam logic [READ_BITS-1:0]   VAL_ONES    = '1;
  localparam logic [READ_BITS-1:0]   VAL_MIXED   = 44'h123456789AB;
  localparam int unsigned QUIET_LIMIT  = 3 * NODE_COUNT;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          HOLD_AT      = 600;
  localparam int          BUSY_ITEMS   = 1450;
  localparam int          STEADY_ITEMS = 450;
  localparam int          MAX_REPORTS  = 10;
  localparam int          DIRECTED_ROWS = 25;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [ACTION_BITS-1:0]      action_i     = ACT_READ;
  logic signed [READ_BITS-1:0] value_i      = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic signed [READ_BITS-1:0] read_value_o;

  // typed expectation travelling with the item, used for directed rows
  logic                        item_has_exp = 1'b0;
  logic [READ_BITS-1:0]        item_exp     = '0;

  bit                          idle_on      = 1'b1;
  int                          items_taken  = 0;
  int                          error_count  = 0;
  int unsigned                 quiet_cycles = 0;
  logic [READ_BITS-1:0]        pending_reads[$];

  // list predictor state
  bit   [WORD_BITS-1:0]        node_words[int unsigned];
  logic [INDEX_BITS-1:0]       cur_idx   = CUR_RST;
  logic [INDEX_BITS-1:0]       left_idx  = CUR_LEFT_RST;
  logic [INDEX_BITS-1:0]       right_idx = CUR_RIGHT_RST;
  logic [INDEX_BITS-1:0]       top_idx   = FREE_TOP_RST;
  logic [INDEX_BITS-1:0]       below_idx = FREE_BELOW_RST;
  logic [INDEX_BITS-1:0]       above_idx = FREE_ABOVE_RST;

  typedef struct {
    logic [ACTION_BITS-1:0] act;
    logic [READ_BITS-1:0]   val;
    bit                     has_exp;
    logic [READ_BITS-1:0]   exp_val;
  } edit_row_t;

  edit_row_t directed_rows[DIRECTED_ROWS] = '{
    '{ACT_READ,      '0,        1'b1, VAL_ONES},
    '{ACT_OVERWRITE, VAL_MAX,   1'b0, '0},
    '{ACT_READ,      '0,        1'b1, VAL_MAX},
    '{ACT_OVERWRITE, VAL_MIN,   1'b0, '0},
    '{ACT_READ,      VAL_ONES,  1'b1, VAL_MIN},
    '{ACT_SPARE_6,   VAL_ONES,  1'b0, '0},
    '{ACT_SPARE_7,   '0,        1'b0, '0},
    '{ACT_READ,      '0,        1'b1, VAL_MIN},
    '{ACT_INSERT,    '0,        1'b0, '0},
    '{ACT_READ,      '0,        1'b1, '0},
    '{ACT_LEFT,      VAL_MAX,   1'b0, '0},
    '{ACT_READ,      '0,        1'b1, VAL_MIN},
    '{ACT_RIGHT,     VAL_MIN,   1'b0, '0},
    '{ACT_READ,      '0,        1'b0, '0},
    '{ACT_DELETE,    VAL_ONES,  1'b0, '0},
    '{ACT_READ,      '0,        1'b0, '0},
    '{ACT_DELETE,    '0,        1'b0, '0},
    '{ACT_RIGHT,     '0,        1'b0, '0},
    '{ACT_LEFT,      '0,        1'b0, '0},
    '{ACT_LEFT,      '0,        1'b0, '0},
    '{ACT_READ,      '0,        1'b0, '0},
    '{ACT_OVERWRITE, VAL_MIXED, 1'b0, '0},
    '{ACT_READ,      '0,        1'b0, '0},
    '{ACT_RIGHT,     '0,        1'b0, '0},
    '{ACT_READ,      '0,        1'b0, '0}
  };

  xor_linked_list_cursor_editor u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // untouched nodes still hold the reset chain; indices past the store read as zero
  function automatic bit [WORD_BITS-1:0] node_word(logic [INDEX_BITS-1:0] idx);
    logic [INDEX_BITS-1:0] lo;
    if (idx >= NODE_COUNT) return '0;
    if (node_words.exists(idx)) return node_words[idx];
    lo = (idx == 0) ? '0 : idx - 1'b1;
    return {{VAL_BITS{1'b1}}, lo ^ (idx + 1'b1)};
  endfunction

  function automatic logic [INDEX_BITS-1:0] node_link(logic [INDEX_BITS-1:0] idx);
    bit [WORD_BITS-1:0] w;
    w = node_word(idx);
    return w[INDEX_BITS-1:0];
  endfunction

  function automatic logic [VAL_BITS-1:0] node_value(logic [INDEX_BITS-1:0] idx);
    bit [WORD_BITS-1:0] w;
    w = node_word(idx);
    return w[WORD_BITS-1:INDEX_BITS];
  endfunction

  function automatic void store_node(logic [INDEX_BITS-1:0] idx, logic [INDEX_BITS-1:0] lft,
                                     logic [VAL_BITS-1:0] val, logic [INDEX_BITS-1:0] rgt);
    if (idx < NODE_COUNT) node_words[idx] = {val, lft ^ rgt};
  endfunction

  function automatic bit predict_edit(logic [ACTION_BITS-1:0] act, logic [READ_BITS-1:0] val,
                                      output logic [READ_BITS-1:0] rd);
    logic [INDEX_BITS-1:0] fresh;
    logic [INDEX_BITS-1:0] gone;
    logic [INDEX_BITS-1:0] lft;
    rd = '0;
    case (act)
      ACT_LEFT: begin
        right_idx = cur_idx;
        cur_idx   = left_idx;
        left_idx  = node_link(cur_idx) ^ right_idx;
      end
      ACT_RIGHT: begin
        left_idx  = cur_idx;
        cur_idx   = right_idx;
        right_idx = node_link(cur_idx) ^ left_idx;
      end
      ACT_OVERWRITE: store_node(cur_idx, left_idx, val, right_idx);
      ACT_INSERT: begin
        fresh     = top_idx;
        above_idx = top_idx;
        top_idx   = below_idx;
        below_idx = node_link(top_idx) ^ above_idx;
        store_node(cur_idx, left_idx, node_value(cur_idx), fresh);
        store_node(fresh, cur_idx, val, right_idx);
        store_node(right_idx, fresh, node_value(right_idx), node_link(right_idx) ^ cur_idx);
        left_idx = cur_idx;
        cur_idx  = fresh;
      end
      ACT_DELETE: begin
        gone = cur_idx;
        lft  = left_idx;
        store_node(lft, node_link(lft) ^ cur_idx, node_value(lft), right_idx);
        store_node(right_idx, lft, node_value(right_idx), node_link(right_idx) ^ cur_idx);
        cur_idx  = lft;
        left_idx = node_link(lft) ^ right_idx;
        // deleted node goes on top of the free stack
        store_node(top_idx, below_idx, '1, gone);
        store_node(gone, top_idx, '1, gone);
        below_idx = top_idx;
        top_idx   = gone;
        above_idx = gone;
      end
      ACT_READ: begin
        rd = node_value(cur_idx);
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [READ_BITS-1:0] random_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_ONES;
      default: return r[READ_BITS-1:0];
    endcase
  endfunction

  function automatic logic [ACTION_BITS-1:0] random_action();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) return ACT_LEFT;
    if (pick < 28) return ACT_RIGHT;
    if (pick < 40) return ACT_OVERWRITE;
    if (pick < 55) return ACT_INSERT;
    if (pick < 68) return ACT_DELETE;
    if (pick < 95) return ACT_READ;
    return pick[0] ? ACT_SPARE_6 : ACT_SPARE_7;
  endfunction

  task automatic send_item(input logic [ACTION_BITS-1:0] act, input logic [READ_BITS-1:0] val,
                           input bit has_exp, input logic [READ_BITS-1:0] exp_val);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    value_i      <= val;
    item_has_exp <= has_exp;
    item_exp     <= exp_val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    int sent;
    logic [ACTION_BITS-1:0] act;
    sent = 0;
    while (sent < count) begin
      act = random_action();
      send_item(act, random_value(), 1'b0, '0);
      if (act != ACT_SPARE_6 && act != ACT_SPARE_7) sent++;
    end
  endtask

  task automatic drain_reads();
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    logic [READ_BITS-1:0] want;
    logic [READ_BITS-1:0] predicted;
    bit moved;
    moved = 1'b0;
    if (out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (pending_reads.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected read item: actual %h", read_value_o);
      end else begin
        want = pending_reads.pop_front();
        if (read_value_o !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("read_value mismatch: expected %h actual %h", want, read_value_o);
        end
      end
    end
    if (in_valid_i && !in_stall_o) begin
      moved = 1'b1;
      items_taken++;
      if (predict_edit(action_i, value_i, predicted))
        pending_reads.push_back(item_has_exp ? item_exp : predicted);
    end
    if (moved) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin : result_side
    int burst;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && items_taken >= HOLD_AT) begin
        // long hold-off: the read register fills and the input backs up
        held = 1'b1;
        out_stall_i <= 1'b1;
        for (burst = 0; burst < HOLD_CYCLES; burst++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        burst = $urandom_range(1, 16);
        repeat (burst - 1) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("xor_linked_list_cursor_editor regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].val,
                directed_rows[i].has_exp, directed_rows[i].exp_val);
    send_random(BUSY_ITEMS);
    drain_reads();
    idle_on = 1'b0;
    send_random(STEADY_ITEMS);
    drain_reads();
    @(negedge clk_i);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("xor_linked_list_cursor_editor regression: pass");
    end else begin
      $display("xor_linked_list_cursor_editor regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/xlce_pkg.sv
rtl/core/xlce_ram.sv
rtl/core/xlce_ctrl.sv
rtl/core/xor_linked_list_cursor_editor.sv
sim/xor_linked_list_cursor_editor_tb.sv
